FILE: rtl/i2cbm_pkg.sv
// Shared types, codes and widths for the byte-level I2C master.
// Used by i2cbm_seq, i2cbm_skid and i2c_byte_master; depends on nothing.
package i2cbm_pkg;

    localparam int unsigned PHASE_W      = 16;
    localparam int unsigned BIT_CNT_W    = 4;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned S_TDATA_W    = 24;
    localparam int unsigned S_TUSER_W    = 3;
    localparam int unsigned M_TDATA_W    = 16;
    localparam logic [PHASE_W-1:0] PHASE_TICKS_RESET = 16'd1;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Command kinds carried on s_tuser.
    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_WRITE = 3'd2;
    localparam logic [2:0] KIND_READ  = 3'd3;
    localparam logic [2:0] KIND_STOP  = 3'd4;

    // Completion status codes.
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_BUSY = 2'd1;
    localparam logic [1:0] STATUS_NACK = 2'd2;

    typedef struct packed {
        logic [2:0] kind;
        logic [6:0] device_address;
        logic       read_direction;
        logic [7:0] write_data;
        logic       last_read;
        logic       sda_in;
    } cmd_t;

    // The last member sits in the lowest bit, so the flat vector matches m_tdata.
    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] status;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive;
        logic       sda_out;
        logic       scl_out;
    } result_t;

    localparam int unsigned RESULT_W = $bits(result_t);

endpackage

FILE: rtl/i2cbm_seq.sv
// Bus sequencer: phase state, tick timer, bit counter and shift register.
// One call of the step logic per accepted item. Depends on i2cbm_pkg.
module i2cbm_seq (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              step_valid,
    input  i2cbm_pkg::cmd_t                   cmd,
    input  logic [i2cbm_pkg::PHASE_W-1:0]     phase_ticks,
    output i2cbm_pkg::result_t                res
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C,
        PH_TX_LO, PH_TX_HI, PH_TXA_LO, PH_TXA_HI,
        PH_RX_LO, PH_RX_HI, PH_RXA_LO, PH_RXA_HI,
        PH_SP_A, PH_SP_B, PH_SP_C, PH_SP_D
    } phase_t;

    phase_t                                 phase_reg, phase_next, phase_eff;
    logic [i2cbm_pkg::BIT_CNT_W-1:0]        bit_cnt_reg, bit_cnt_next, bit_cnt_eff, bit_cnt_inc;
    logic [i2cbm_pkg::BYTE_W-1:0]           shift_reg, shift_next, shift_eff;
    logic [i2cbm_pkg::PHASE_W-1:0]          tick_reg, tick_next, tick_eff, phase_len;
    logic [i2cbm_pkg::PHASE_W:0]            tick_inc;
    logic                                   ack_reg, ack_next, ack_eff;
    logic [1:0]                             status_reg, status_next;
    logic                                   scl_level_reg, scl_level_next;
    logic                                   sda_level_reg, sda_level_next;
    logic [i2cbm_pkg::BYTE_W-1:0]           read_hold_reg, read_hold_next;
    logic                                   start_cmd, phase_end, done, scl_o, sda_o, drv;

    always_comb begin
        start_cmd = (phase_reg == PH_IDLE) && (cmd.kind >= i2cbm_pkg::KIND_START)
                    && (cmd.kind <= i2cbm_pkg::KIND_STOP);
        phase_eff = phase_reg;
        bit_cnt_eff = bit_cnt_reg;
        shift_eff = shift_reg;
        tick_eff = tick_reg;
        ack_eff = ack_reg;

        // A new command loads its first phase and is stepped on the same tick.
        if (start_cmd) begin
            tick_eff = '0;
            bit_cnt_eff = '0;
            case (cmd.kind)
                i2cbm_pkg::KIND_START: begin
                    shift_eff = {cmd.device_address, cmd.read_direction};
                    phase_eff = PH_ST_A;
                end
                i2cbm_pkg::KIND_WRITE: begin
                    shift_eff = cmd.write_data;
                    phase_eff = PH_TX_LO;
                end
                i2cbm_pkg::KIND_READ: begin
                    shift_eff = '0;
                    ack_eff = cmd.last_read;
                    phase_eff = PH_RX_LO;
                end
                default: begin
                    phase_eff = PH_SP_A;
                end
            endcase
        end

        drv = 1'b1;
        case (phase_eff)
            PH_ST_A:   begin scl_o = 1'b1; sda_o = 1'b1; end
            PH_ST_B:   begin scl_o = 1'b1; sda_o = 1'b0; end
            PH_ST_C:   begin scl_o = 1'b0; sda_o = 1'b0; end
            PH_TX_LO:  begin scl_o = 1'b0; sda_o = shift_eff[i2cbm_pkg::BYTE_W-1]; end
            PH_TX_HI:  begin scl_o = 1'b1; sda_o = shift_eff[i2cbm_pkg::BYTE_W-1]; end
            PH_TXA_LO: begin scl_o = 1'b0; sda_o = 1'b1; drv = 1'b0; end
            PH_TXA_HI: begin scl_o = 1'b1; sda_o = 1'b1; drv = 1'b0; end
            PH_RX_LO:  begin scl_o = 1'b0; sda_o = 1'b1; drv = 1'b0; end
            PH_RX_HI:  begin scl_o = 1'b1; sda_o = 1'b1; drv = 1'b0; end
            PH_RXA_LO: begin scl_o = 1'b0; sda_o = ack_eff; end
            PH_RXA_HI: begin scl_o = 1'b1; sda_o = ack_eff; end
            PH_SP_A:   begin scl_o = 1'b0; sda_o = sda_level_reg; end
            PH_SP_B:   begin scl_o = 1'b0; sda_o = 1'b0; end
            PH_SP_C:   begin scl_o = 1'b1; sda_o = 1'b0; end
            PH_SP_D:   begin scl_o = 1'b1; sda_o = 1'b1; end
            default:   begin scl_o = scl_level_reg; sda_o = sda_level_reg; end
        endcase

        phase_next = phase_eff;
        bit_cnt_next = bit_cnt_eff;
        shift_next = shift_eff;
        tick_next = tick_eff;
        ack_next = ack_eff;
        status_next = status_reg;
        scl_level_next = scl_level_reg;
        sda_level_next = sda_level_reg;
        read_hold_next = read_hold_reg;
        done = 1'b0;

        // A zero phase length behaves as one tick.
        phase_len = (phase_ticks == '0) ? {{(i2cbm_pkg::PHASE_W-1){1'b0}}, 1'b1} : phase_ticks;
        tick_inc = {1'b0, tick_eff} + {{i2cbm_pkg::PHASE_W{1'b0}}, 1'b1};
        phase_end = (tick_inc >= {1'b0, phase_len});
        bit_cnt_inc = bit_cnt_eff + {{(i2cbm_pkg::BIT_CNT_W-1){1'b0}}, 1'b1};

        if (phase_eff != PH_IDLE) begin
            tick_next = phase_end ? '0 : tick_inc[i2cbm_pkg::PHASE_W-1:0];
            if (phase_end) begin
                case (phase_eff)
                    PH_ST_A: begin
                        if (!cmd.sda_in) begin
                            status_next = i2cbm_pkg::STATUS_BUSY;
                            scl_level_next = 1'b1;
                            sda_level_next = 1'b1;
                            phase_next = PH_IDLE;
                            done = 1'b1;
                        end else begin
                            phase_next = PH_ST_B;
                        end
                    end
                    PH_ST_B: begin
                        if (cmd.sda_in) begin
                            status_next = i2cbm_pkg::STATUS_BUSY;
                            scl_level_next = 1'b1;
                            sda_level_next = 1'b1;
                            phase_next = PH_IDLE;
                            done = 1'b1;
                        end else begin
                            phase_next = PH_ST_C;
                        end
                    end
                    PH_ST_C: begin
                        bit_cnt_next = '0;
                        phase_next = PH_TX_LO;
                    end
                    PH_TX_LO:  phase_next = PH_TX_HI;
                    PH_TX_HI: begin
                        shift_next = {shift_eff[i2cbm_pkg::BYTE_W-2:0], 1'b0};
                        bit_cnt_next = bit_cnt_inc;
                        phase_next = (bit_cnt_inc >= i2cbm_pkg::BITS_PER_BYTE) ? PH_TXA_LO
                                                                               : PH_TX_LO;
                    end
                    PH_TXA_LO: phase_next = PH_TXA_HI;
                    PH_TXA_HI: begin
                        status_next = cmd.sda_in ? i2cbm_pkg::STATUS_NACK : i2cbm_pkg::STATUS_OK;
                        scl_level_next = 1'b1;
                        sda_level_next = 1'b1;
                        phase_next = PH_IDLE;
                        done = 1'b1;
                    end
                    PH_RX_LO:  phase_next = PH_RX_HI;
                    PH_RX_HI: begin
                        shift_next = {shift_eff[i2cbm_pkg::BYTE_W-2:0], cmd.sda_in};
                        bit_cnt_next = bit_cnt_inc;
                        phase_next = (bit_cnt_inc >= i2cbm_pkg::BITS_PER_BYTE) ? PH_RXA_LO
                                                                               : PH_RX_LO;
                    end
                    PH_RXA_LO: phase_next = PH_RXA_HI;
                    PH_RXA_HI: begin
                        read_hold_next = shift_eff;
                        status_next = i2cbm_pkg::STATUS_OK;
                        scl_level_next = 1'b1;
                        sda_level_next = ack_eff;
                        phase_next = PH_IDLE;
                        done = 1'b1;
                    end
                    PH_SP_A:   phase_next = PH_SP_B;
                    PH_SP_B:   phase_next = PH_SP_C;
                    PH_SP_C:   phase_next = PH_SP_D;
                    default: begin
                        status_next = i2cbm_pkg::STATUS_OK;
                        scl_level_next = 1'b1;
                        sda_level_next = 1'b1;
                        phase_next = PH_IDLE;
                        done = 1'b1;
                    end
                endcase
            end
        end

        res.scl_out = scl_o;
        res.sda_out = sda_o;
        res.sda_drive = drv;
        res.busy_res = (phase_eff != PH_IDLE);
        res.done_res = done;
        res.status = status_next;
        res.read_data = read_hold_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            bit_cnt_reg <= '0;
            shift_reg <= '0;
            tick_reg <= '0;
            ack_reg <= 1'b0;
            status_reg <= i2cbm_pkg::STATUS_OK;
            scl_level_reg <= 1'b1;
            sda_level_reg <= 1'b1;
            read_hold_reg <= '0;
        end else if (step_valid) begin
            phase_reg <= phase_next;
            bit_cnt_reg <= bit_cnt_next;
            shift_reg <= shift_next;
            tick_reg <= tick_next;
            ack_reg <= ack_next;
            status_reg <= status_next;
            scl_level_reg <= scl_level_next;
            sda_level_reg <= sda_level_next;
            read_hold_reg <= read_hold_next;
        end
    end

    // A finishing tick always belongs to the command.
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        step_valid && res.done_res |-> res.busy_res)
        else $error("done without busy");

    // After a finishing tick the sequencer is back in idle.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step_valid && res.done_res |=> phase_reg == PH_IDLE)
        else $error("sequencer not idle after done");

    // The bit counter never passes one byte.
    a_bit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_cnt_reg <= i2cbm_pkg::BITS_PER_BYTE)
        else $error("bit counter out of range");

    // When SDA is released to the slave, the driven level shows released.
    a_release: assert property (@(posedge aclk) disable iff (!aresetn)
        step_valid && !res.sda_drive |-> res.sda_out)
        else $error("sda low while not driven");

endmodule

FILE: rtl/i2cbm_skid.sv
// Two-entry output buffer: result register plus a skid stage.
// Keeps the input side ready while one result waits. Depends on i2cbm_pkg.
module i2cbm_skid (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  i2cbm_pkg::result_t     in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output i2cbm_pkg::result_t     out_data
);

    logic               out_valid_reg, skid_valid_reg;
    i2cbm_pkg::result_t out_data_reg, skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            if (out_valid_reg && !out_ready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (out_valid_reg && out_ready) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            if (out_valid_reg && !out_ready) begin
                skid_data_reg <= in_data;
            end else begin
                out_data_reg <= in_data;
            end
        end else if (out_valid_reg && out_ready && skid_valid_reg) begin
            out_data_reg <= skid_data_reg;
        end
    end

endmodule

FILE: rtl/i2c_byte_master.sv
// Top level of the byte-level I2C master: configuration register, sequencer
// and output buffer. Depends on i2cbm_pkg, i2cbm_seq and i2cbm_skid.
//
// Each transfer on the s_ channel is one tick of the I2C bit clock: it may
// carry a command (start plus address, write byte, read byte, stop) in
// s_tuser, and always carries the sampled SDA level. A command is taken only
// while the sequencer is idle; otherwise the kind is ignored and the transfer
// just advances the bus timing. Every SCL half-bit phase lasts phase_ticks
// ticks (zero acts as one), written through the cfg_ port; the user writes it
// only while the block is idle, which it does not enforce. Every input transfer
// produces exactly one result transfer on the m_ channel with the pin levels
// for that tick, busy, a done pulse, the status of the last finished command
// and the last byte read. The block takes one item per clock cycle while
// s_tready is high: each step is one pass of logic from the sequencer registers
// into a registered two-entry output buffer, which keeps s_tready high while
// one result waits on m_tready; s_tready drops only when both are full.
module i2c_byte_master (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration: phase_ticks.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [i2cbm_pkg::PHASE_W-1:0]       cfg_data,
    // Input items.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [6:0] device_address, [7] read_direction, [15:8] write_data,
    // [16] last_read, [17] sda_in, [23:18] zero.
    input  logic [i2cbm_pkg::S_TDATA_W-1:0]     s_tdata,
    // [2:0] kind.
    input  logic [i2cbm_pkg::S_TUSER_W-1:0]     s_tuser,
    // Result items.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] scl_out, [1] sda_out, [2] sda_drive, [3] busy_res, [4] done_res,
    // [6:5] status, [14:7] read_data, [15] zero.
    output logic [i2cbm_pkg::M_TDATA_W-1:0]     m_tdata
);

    logic [i2cbm_pkg::PHASE_W-1:0] phase_ticks_reg;
    i2cbm_pkg::cmd_t               cmd;
    i2cbm_pkg::result_t            step_res, out_res;
    logic                          step_valid;

    // The configuration register is always ready to take a write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= i2cbm_pkg::PHASE_TICKS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            phase_ticks_reg <= cfg_data;
        end
    end

    // Unpack the input fields.
    assign cmd.kind           = s_tuser;
    assign cmd.device_address = s_tdata[6:0];
    assign cmd.read_direction = s_tdata[7];
    assign cmd.write_data     = s_tdata[15:8];
    assign cmd.last_read      = s_tdata[16];
    assign cmd.sda_in         = s_tdata[17];

    assign step_valid = s_tvalid && s_tready;

    i2cbm_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_valid  (step_valid),
        .cmd         (cmd),
        .phase_ticks (phase_ticks_reg),
        .res         (step_res)
    );

    i2cbm_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (step_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {{(i2cbm_pkg::M_TDATA_W - i2cbm_pkg::RESULT_W){1'b0}}, out_res};

endmodule
